FILE: design/mbim_pkg.sv
// shared types, codes and line action functions for the multi-bus i2c host
`timescale 1ns / 1ps
package mbim_pkg;

  localparam int BUS_LANES = 8;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_INIT   = 3'd1;
  localparam logic [2:0] CMD_WSTART = 3'd2;
  localparam logic [2:0] CMD_RSTART = 3'd3;
  localparam logic [2:0] CMD_WBYTE  = 3'd4;
  localparam logic [2:0] CMD_RBYTE  = 3'd5;

  localparam logic REG_BUS_COUNT = 1'b0;
  localparam logic [3:0] BUS_COUNT_RESET = 4'd8;

  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_INIT   = 3'd1,
    OP_WSTART = 3'd2,
    OP_RSTART = 3'd3,
    OP_WBYTE  = 3'd4,
    OP_RBYTE  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [63:0] write_bytes;
    logic        keep_going;
    logic [7:0]  sda_sample;
  } item_t;

  typedef struct packed {
    logic        scl_drive_low;
    logic [7:0]  sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [7:0]  nack_buses;
    logic [63:0] read_bytes;
  } res_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  step;
    logic [63:0] shift_out;
    logic [63:0] shift_in;
    logic [7:0]  nack;
    logic        cont;
    logic        scl;
    logic [7:0]  sda;
  } seq_state_t;

  typedef struct packed {
    logic       scl_we;
    logic       scl_v;
    logic       sda_we;
    logic [7:0] sda_v;
    logic [7:0] nk;
    logic       rd_we;
    logic [2:0] rd_bit;
  } act_t;

  // one action of a byte write: eight bits of three actions, then the ack slot
  function automatic act_t wr_act(input logic [4:0] j, input logic [63:0] bytes,
                                  input logic [7:0] sample, input logic [7:0] amask);
    act_t a;
    logic [1:0] sub;
    logic [2:0] bitn;
    logic [7:0] pat;
    a = '0;
    sub = '0;
    bitn = '0;
    pat = '0;
    for (int k = 0; k < 8; k++) begin
      if (j >= 5'(3 * k) && j < 5'(3 * k + 3)) begin
        sub = 2'(j - 5'(3 * k));
        bitn = 3'(7 - k);
      end
    end
    for (int k = 0; k < BUS_LANES; k++) begin
      pat[k] = ~bytes[8 * k + int'(bitn)];
    end
    if (j < 5'd24) begin
      case (sub)
        2'd0: begin
          a.scl_we = 1'b1;
          a.scl_v = 1'b1;
        end
        2'd1: begin
          a.sda_we = 1'b1;
          a.sda_v = pat & amask;
        end
        default: begin
          a.scl_we = 1'b1;
          a.scl_v = 1'b0;
        end
      endcase
    end else begin
      case (j)
        5'd24: begin
          a.scl_we = 1'b1;
          a.scl_v = 1'b1;
        end
        5'd25: begin
          a.sda_we = 1'b1;
          a.sda_v = 8'h00;
        end
        5'd26: begin
          a.scl_we = 1'b1;
          a.scl_v = 1'b0;
        end
        default: begin
          a.nk = sample & amask;
        end
      endcase
    end
    return a;
  endfunction

  // stop and init share this order
  function automatic act_t stop_act(input logic [1:0] j, input logic [7:0] amask);
    act_t a;
    a = '0;
    case (j)
      2'd0: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b1;
      end
      2'd1: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b0;
      end
      2'd2: begin
        a.sda_we = 1'b1;
        a.sda_v = amask;
      end
      default: begin
        a.sda_we = 1'b1;
        a.sda_v = 8'h00;
      end
    endcase
    return a;
  endfunction

  function automatic act_t ack_act(input logic [1:0] j, input logic [7:0] amask);
    act_t a;
    a = '0;
    case (j)
      2'd0: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b1;
      end
      2'd1: begin
        a.sda_we = 1'b1;
        a.sda_v = amask;
      end
      default: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b0;
      end
    endcase
    return a;
  endfunction

  function automatic act_t nack_stop_act(input logic [2:0] j, input logic [7:0] amask);
    act_t a;
    a = '0;
    case (j)
      3'd0: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b1;
      end
      3'd1: begin
        a.sda_we = 1'b1;
        a.sda_v = 8'h00;
      end
      3'd2: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b0;
      end
      default: begin
        a = stop_act(2'(j - 3'd3), amask);
      end
    endcase
    return a;
  endfunction

  // one action of a byte read: four actions per bit, msb first
  function automatic act_t rd_act(input logic [4:0] j);
    act_t a;
    a = '0;
    case (j[1:0])
      2'd0: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b1;
      end
      2'd1: begin
        a.sda_we = 1'b1;
        a.sda_v = 8'h00;
      end
      2'd2: begin
        a.scl_we = 1'b1;
        a.scl_v = 1'b0;
      end
      default: begin
        a.rd_we = 1'b1;
        a.rd_bit = 3'd7 - j[4:2];
      end
    endcase
    return a;
  endfunction

endpackage

FILE: design/mbim_apb_regs.sv
// apb register file holding the active bus count
`timescale 1ns / 1ps
module mbim_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  bus_count
);
  import mbim_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_BUS_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_count <= BUS_COUNT_RESET;
    end else if (wr_en) begin
      bus_count <= pwdata[3:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUS_COUNT) begin
      prdata = {28'd0, bus_count};
    end else begin
      prdata = 32'd0;
    end
  end

  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

FILE: design/mbim_seq.sv
// sequencer step logic: one line action per tick item, command loading when idle
`timescale 1ns / 1ps
module mbim_seq #(
  parameter int MAX_BUSES = 8
) (
  input  mbim_pkg::seq_state_t cur,
  input  mbim_pkg::item_t      item,
  input  logic [3:0]           bus_count,
  output mbim_pkg::seq_state_t nxt,
  output mbim_pkg::res_t       res
);
  import mbim_pkg::*;

  logic [3:0] n_act;
  logic [7:0] amask;
  logic [7:0] samp;
  logic       is_cmd;
  logic       fin;
  logic       jump;
  logic       done;
  logic       ok;
  logic [6:0] s;
  act_t       act;

  always_comb begin
    if (bus_count == 4'd0) begin
      n_act = 4'd1;
    end else if (bus_count > 4'(MAX_BUSES)) begin
      n_act = 4'(MAX_BUSES);
    end else begin
      n_act = bus_count;
    end
    if (n_act >= 4'd8) begin
      amask = 8'hFF;
    end else begin
      amask = 8'((9'd1 << n_act) - 9'd1);
    end
  end

  assign samp = item.sda_sample & amask;
  assign is_cmd = (item.cmd >= CMD_INIT) && (item.cmd <= CMD_RBYTE);
  assign s = cur.step;

  always_comb begin
    nxt = cur;
    act = '0;
    fin = 1'b0;
    jump = 1'b0;
    done = 1'b0;
    ok = 1'b0;
    if (cur.op == OP_IDLE) begin
      if (is_cmd) begin
        nxt.step = 7'd0;
        nxt.nack = 8'h00;
        nxt.cont = item.keep_going;
        case (item.cmd)
          CMD_INIT: begin
            nxt.op = OP_INIT;
          end
          CMD_WSTART: begin
            nxt.op = OP_WSTART;
            nxt.shift_out = {48'd0, item.reg_addr, item.dev_addr};
          end
          CMD_RSTART: begin
            nxt.op = OP_RSTART;
            nxt.shift_out = {56'd0, item.dev_addr | 8'h01};
          end
          CMD_WBYTE: begin
            nxt.op = OP_WBYTE;
            nxt.shift_out = item.write_bytes;
          end
          default: begin
            nxt.op = OP_RBYTE;
            nxt.shift_in = 64'd0;
          end
        endcase
      end
    end else if (!is_cmd) begin
      case (cur.op)
        OP_INIT: begin
          act = stop_act(s[1:0], amask);
          fin = (s >= 7'd3);
        end
        OP_WSTART: begin
          if (s == 7'd0) begin
            act.sda_we = 1'b1;
            act.sda_v = amask;
          end else if (s <= 7'd28) begin
            act = wr_act(5'(s - 7'd1), {8{cur.shift_out[7:0]}}, item.sda_sample, amask);
            jump = (s == 7'd28) && (act.nk != 8'h00);
          end else if (s <= 7'd56) begin
            act = wr_act(5'(s - 7'd29), {8{cur.shift_out[15:8]}}, item.sda_sample, amask);
            fin = (s == 7'd56) && (act.nk == 8'h00) && cur.cont;
          end else begin
            act = stop_act(2'(s - 7'd57), amask);
            fin = (s >= 7'd60);
          end
        end
        OP_RSTART: begin
          if (s == 7'd0) begin
            act.sda_we = 1'b1;
            act.sda_v = amask;
          end else if (s <= 7'd28) begin
            act = wr_act(5'(s - 7'd1), {8{cur.shift_out[7:0]}}, item.sda_sample, amask);
            fin = (s == 7'd28) && (act.nk == 8'h00) && cur.cont;
          end else begin
            act = stop_act(2'(s - 7'd29), amask);
            fin = (s >= 7'd32);
          end
        end
        OP_WBYTE: begin
          if (s <= 7'd27) begin
            act = wr_act(s[4:0], cur.shift_out, item.sda_sample, amask);
            fin = (s == 7'd27) && (act.nk == 8'h00) && cur.cont;
          end else begin
            act = stop_act(2'(s - 7'd28), amask);
            fin = (s >= 7'd31);
          end
        end
        OP_RBYTE: begin
          if (s <= 7'd31) begin
            act = rd_act(s[4:0]);
          end else if (cur.cont) begin
            act = ack_act(2'(s - 7'd32), amask);
            fin = (s >= 7'd34);
          end else begin
            act = nack_stop_act(3'(s - 7'd32), amask);
            fin = (s >= 7'd38);
          end
        end
        default: begin
          act = '0;
        end
      endcase

      if (act.scl_we) begin
        nxt.scl = act.scl_v;
      end
      if (act.sda_we) begin
        nxt.sda = act.sda_v;
      end
      nxt.nack = cur.nack | act.nk;
      if (act.rd_we) begin
        for (int k = 0; k < BUS_LANES; k++) begin
          if (samp[k]) begin
            nxt.shift_in[8 * k + int'(act.rd_bit)] = 1'b1;
          end
        end
      end
      if (jump) begin
        nxt.step = 7'd57;
      end else begin
        nxt.step = s + 7'd1;
      end
      if (fin) begin
        nxt.op = OP_IDLE;
        nxt.step = 7'd0;
        done = 1'b1;
        ok = (nxt.nack == 8'h00);
      end
    end
  end

  always_comb begin
    res.scl_drive_low = nxt.scl;
    res.sda_drive_low = nxt.sda;
    res.busy_res = (nxt.op != OP_IDLE);
    res.done_res = done;
    res.success = ok;
    res.nack_buses = nxt.nack;
    res.read_bytes = nxt.shift_in;
  end

endmodule

FILE: design/multi_bus_i2c_master.sv
// top level of the multi-bus i2c host: stream ports, state and result registers
// the result of an accepted item is in the output register in the cycle after it is accepted
// throughput: one item per cycle; the sequencer does one line action per tick item
// the input side stays ready while the output register is empty or being taken
// reset (rst, synchronous): idle, lines released, masks and shift registers zero
// bus_count resets to 8; the output register comes out of reset empty
`timescale 1ns / 1ps
module multi_bus_i2c_master #(
  parameter int MAX_BUSES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // dev_addr, reg_addr, write_bytes, keep_going, sda_sample, zero pad
  input  logic [95:0] s_tdata,
  // cmd
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_drive_low, sda_drive_low, busy_res, done_res, success, nack_buses,
  // read_bytes, zero pad
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbim_pkg::*;

  logic [3:0] bus_count;
  item_t      item;
  seq_state_t st;
  seq_state_t st_next;
  res_t       res_next;
  res_t       res_q;
  logic       acc;
  logic       unused_pad;

  mbim_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .bus_count (bus_count)
  );

  assign item.cmd         = s_tuser;
  assign item.dev_addr    = s_tdata[7:0];
  assign item.reg_addr    = s_tdata[15:8];
  assign item.write_bytes = s_tdata[79:16];
  assign item.keep_going  = s_tdata[80];
  assign item.sda_sample  = s_tdata[88:81];
  assign unused_pad       = ^s_tdata[95:89];

  mbim_seq #(
    .MAX_BUSES (MAX_BUSES)
  ) u_seq (
    .cur       (st),
    .item      (item),
    .bus_count (bus_count),
    .nxt       (st_next),
    .res       (res_next)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.op <= OP_IDLE;
      st.step <= 7'd0;
      st.shift_out <= 64'd0;
      st.shift_in <= 64'd0;
      st.nack <= 8'h00;
      st.cont <= 1'b0;
      st.scl <= 1'b0;
      st.sda <= 8'h00;
      m_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        st <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res_next;
    end
  end

  assign m_tdata = {4'd0, res_q.read_bytes, res_q.nack_buses, res_q.success,
                    res_q.done_res, res_q.busy_res, res_q.sda_drive_low,
                    res_q.scl_drive_low};

`ifndef SYNTH
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    acc && res_next.done_res |=> st.op == OP_IDLE)
    else $error("sequence done but state not idle");

  a_success_needs_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.success |-> res_q.done_res)
    else $error("success without done");

  a_nack_no_success: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.done_res && (res_q.nack_buses != 8'h00) |-> !res_q.success)
    else $error("success reported with nack buses");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    st.op == OP_IDLE |-> st.step == 7'd0)
    else $error("idle with nonzero step");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    st.step <= 7'd60)
    else $error("step count beyond longest sequence");
`endif

endmodule

FILE: bench/multi_bus_i2c_master_test.sv
// self-checking bench for the multi-bus i2c host: stream stimulus, line predictor, apb setup
`timescale 1ns / 1ps
module multi_bus_i2c_master_test;
  import mbim_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 210;
  localparam int REPORT_CAP = 200;

  localparam res_t OUT_IDLE = '0;
  localparam res_t OUT_BUSY = '{busy_res: 1'b1, default: '0};

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  dev;
    logic [7:0]  regad;
    logic [63:0] data;
    logic        keep;
    logic [7:0]  sample;
    int          reps;
    bit          chk;
    res_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // dev_addr, reg_addr, write_bytes, keep_going, sda_sample, zero pad
  logic [95:0] s_tdata;
  // cmd
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // scl_drive_low, sda_drive_low, busy_res, done_res, success, nack_buses,
  // read_bytes, zero pad
  logic [87:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  multi_bus_i2c_master uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predicted host state
  op_t         seq_op;
  logic [6:0]  seq_step;
  logic [63:0] out_shift;
  logic [63:0] in_shift;
  logic [7:0]  nack_acc;
  logic        keep_flag;
  logic        scl_low;
  logic [7:0]  sda_low;
  logic [3:0]  bus_cnt;

  res_t pending_outcomes[$];
  int   errors = 0;
  int   live_items = 0;
  int   got_count = 0;
  int   quiet_cycles = 0;
  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b0;

  function automatic logic [7:0] lane_mask();
    int n;
    n = bus_cnt;
    if (n < 1) n = 1;
    if (n > BUS_LANES) n = BUS_LANES;
    return (n >= 8) ? 8'hFF : 8'((1 << n) - 1);
  endfunction

  function automatic bit is_tick(logic [2:0] cmd);
    return (cmd == CMD_TICK) || (cmd > CMD_RBYTE);
  endfunction

  function automatic logic [7:0] line_write(int j, logic [63:0] bytes, logic [7:0] sample);
    int bitn;
    logic [7:0] pat;
    if (j < 24) begin
      bitn = 7 - j / 3;
      case (j % 3)
        0: scl_low = 1'b1;
        1: begin
          for (int k = 0; k < 8; k++) pat[k] = ~bytes[8 * k + bitn];
          sda_low = pat & lane_mask();
        end
        default: scl_low = 1'b0;
      endcase
      return 8'h00;
    end
    case (j)
      24: scl_low = 1'b1;
      25: sda_low = 8'h00;
      26: scl_low = 1'b0;
      default: return sample & lane_mask();
    endcase
    return 8'h00;
  endfunction

  function automatic void line_read(int j, logic [7:0] sample);
    logic [7:0] s;
    case (j % 4)
      0: scl_low = 1'b1;
      1: sda_low = 8'h00;
      2: scl_low = 1'b0;
      default: begin
        s = sample & lane_mask();
        for (int k = 0; k < 8; k++)
          if (s[k]) in_shift[8 * k + 7 - j / 4] = 1'b1;
      end
    endcase
  endfunction

  function automatic void line_stop(int j);
    case (j)
      0: scl_low = 1'b1;
      1: scl_low = 1'b0;
      2: sda_low = lane_mask();
      default: sda_low = 8'h00;
    endcase
  endfunction

  function automatic void line_ack(int j);
    case (j)
      0: scl_low = 1'b1;
      1: sda_low = lane_mask();
      default: scl_low = 1'b0;
    endcase
  endfunction

  function automatic void line_nack_stop(int j);
    case (j)
      0: scl_low = 1'b1;
      1: sda_low = 8'h00;
      2: scl_low = 1'b0;
      default: line_stop(j - 3);
    endcase
  endfunction

  // one line action of the running sequence, returns 1 on its last action
  function automatic bit seq_advance(logic [7:0] sample);
    int s;
    int nxt;
    bit fin;
    logic [7:0] nk;
    s = seq_step;
    nxt = s + 1;
    fin = 1'b0;
    case (seq_op)
      OP_INIT: begin
        line_stop(s);
        fin = (s >= 3);
      end
      OP_WSTART: begin
        if (s == 0) begin
          sda_low = lane_mask();
        end else if (s <= 28) begin
          nk = line_write(s - 1, {8{out_shift[7:0]}}, sample);
          nack_acc |= nk;
          if (s == 28 && nk != 0) nxt = 57;
        end else if (s <= 56) begin
          nk = line_write(s - 29, {8{out_shift[15:8]}}, sample);
          nack_acc |= nk;
          if (s == 56 && nk == 0 && keep_flag) fin = 1'b1;
        end else begin
          line_stop(s - 57);
          fin = (s >= 60);
        end
      end
      OP_RSTART: begin
        if (s == 0) begin
          sda_low = lane_mask();
        end else if (s <= 28) begin
          nk = line_write(s - 1, {8{out_shift[7:0]}}, sample);
          nack_acc |= nk;
          if (s == 28 && nk == 0 && keep_flag) fin = 1'b1;
        end else begin
          line_stop(s - 29);
          fin = (s >= 32);
        end
      end
      OP_WBYTE: begin
        if (s <= 27) begin
          nk = line_write(s, out_shift, sample);
          nack_acc |= nk;
          if (s == 27 && nk == 0 && keep_flag) fin = 1'b1;
        end else begin
          line_stop(s - 28);
          fin = (s >= 31);
        end
      end
      OP_RBYTE: begin
        if (s <= 31) begin
          line_read(s, sample);
        end else if (keep_flag) begin
          line_ack(s - 32);
          fin = (s >= 34);
        end else begin
          line_nack_stop(s - 32);
          fin = (s >= 38);
        end
      end
      default: return 1'b0;
    endcase
    seq_step = 7'(nxt);
    return fin;
  endfunction

  function automatic res_t bus_outcome(item_t it);
    res_t r;
    bit fin;
    r = '0;
    if (seq_op == OP_IDLE) begin
      if (!is_tick(it.cmd)) begin
        seq_op = op_t'(it.cmd);
        seq_step = '0;
        nack_acc = '0;
        keep_flag = it.keep_going;
        case (it.cmd)
          CMD_WSTART: out_shift = {48'h0, it.reg_addr, it.dev_addr};
          CMD_RSTART: out_shift = {56'h0, it.dev_addr | 8'h01};
          CMD_WBYTE: out_shift = it.write_bytes;
          CMD_RBYTE: in_shift = '0;
          default: ;
        endcase
      end
    end else if (is_tick(it.cmd)) begin
      fin = seq_advance(it.sda_sample);
      if (fin) begin
        r.done_res = 1'b1;
        r.success = (nack_acc == 0);
        seq_op = OP_IDLE;
        seq_step = '0;
      end
    end
    r.scl_drive_low = scl_low;
    r.sda_drive_low = sda_low;
    r.busy_res = (seq_op != OP_IDLE);
    r.nack_buses = nack_acc;
    r.read_bytes = in_shift;
    return r;
  endfunction

  function automatic int idle_span(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.cmd = 3'($urandom_range(0, 7));
    it.dev_addr = 8'($urandom);
    it.reg_addr = 8'($urandom);
    it.write_bytes = {$urandom, $urandom};
    it.keep_going = 1'($urandom);
    it.sda_sample = 8'($urandom);
    return it;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (errors < REPORT_CAP)
        $display("%0t %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic stim_row_t stim(logic [2:0] cmd, logic [7:0] dev, logic [7:0] regad,
                                     logic [63:0] data, logic keep, logic [7:0] sample,
                                     int reps, bit chk, res_t want);
    stim_row_t r;
    r.cmd = cmd;
    r.dev = dev;
    r.regad = regad;
    r.data = data;
    r.keep = keep;
    r.sample = sample;
    r.reps = reps;
    r.chk = chk;
    r.want = want;
    return r;
  endfunction

  task automatic send_item(input item_t it, input bit chk = 1'b0, input res_t want = '0);
    int gap;
    res_t pred;
    gap = idle_span(tx_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {7'h00, it.sda_sample, it.keep_going, it.write_bytes,
                it.reg_addr, it.dev_addr};
    do @(posedge clk); while (!s_tready);
    if ((seq_op == OP_IDLE) != is_tick(it.cmd)) live_items++;
    pred = bus_outcome(it);
    pending_outcomes.push_back(chk ? want : pred);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_bus_count(input logic [3:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_BUS_COUNT);
    pwdata <= ($urandom & 32'hFFFF_FFF0) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bus_cnt = v;
  endtask

  // a command and its ticks, now and then broken up by stray items
  task automatic transfer();
    item_t it;
    it = random_item();
    it.cmd = 3'($urandom_range(int'(CMD_INIT), int'(CMD_RBYTE)));
    send_item(it);
    while (seq_op != OP_IDLE) begin
      it = random_item();
      if ($urandom_range(0, 19) != 0) it.cmd = CMD_TICK;
      if (seq_op != OP_RBYTE && $urandom_range(0, 3) != 0)
        it.sda_sample = it.sda_sample & ~lane_mask();
      send_item(it);
    end
  endtask

  task automatic random_phase(input int quota);
    int first;
    first = live_items;
    while (live_items - first < quota) begin
      if ($urandom_range(0, 9) == 0) send_item(random_item());
      else transfer();
    end
  endtask

  always @(posedge clk) begin : outcome_check
    res_t want;
    res_t got;
    int stall_left;
    bit held;
    if (!rst && m_tvalid && m_tready) begin
      got.scl_drive_low = m_tdata[0];
      got.sda_drive_low = m_tdata[8:1];
      got.busy_res = m_tdata[9];
      got.done_res = m_tdata[10];
      got.success = m_tdata[11];
      got.nack_buses = m_tdata[19:12];
      got.read_bytes = m_tdata[83:20];
      got_count++;
      if (pending_outcomes.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t unexpected item expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("scl_drive_low", 64'(want.scl_drive_low), 64'(got.scl_drive_low));
        check_field("sda_drive_low", 64'(want.sda_drive_low), 64'(got.sda_drive_low));
        check_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
        check_field("done_res", 64'(want.done_res), 64'(got.done_res));
        check_field("success", 64'(want.success), 64'(got.success));
        check_field("nack_buses", 64'(want.nack_buses), 64'(got.nack_buses));
        check_field("read_bytes", want.read_bytes, got.read_bytes);
      end
    end
    // one long hold-off so the block fills up and stalls its input
    if (!held && got_count >= 700) begin
      held = 1'b1;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_span(rx_idle);
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_bus_i2c_master: mismatch");
      $finish;
    end
  end

  initial begin : main
    stim_row_t script [21];
    item_t it;
    logic [3:0] cnt;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_TICK;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seq_op = OP_IDLE;
    seq_step = '0;
    out_shift = '0;
    in_shift = '0;
    nack_acc = '0;
    keep_flag = 1'b0;
    scl_low = 1'b0;
    sda_low = '0;
    bus_cnt = BUS_COUNT_RESET;

    script[0]  = stim(CMD_TICK, 8'hFF, 8'hFF, '1, 1'b1, 8'hFF, 1, 1'b1, OUT_IDLE);
    script[1]  = stim(3'd7, 8'h00, 8'h00, '0, 1'b0, 8'h00, 1, 1'b1, OUT_IDLE);
    script[2]  = stim(CMD_INIT, 8'h00, 8'h00, '0, 1'b0, 8'h00, 1, 1'b1, OUT_BUSY);
    // command while busy is dropped
    script[3]  = stim(CMD_RSTART, 8'h5A, 8'hA5, '1, 1'b1, 8'hFF, 1, 1'b1, OUT_BUSY);
    // unknown code acts as a tick
    script[4]  = stim(3'd6, 8'h00, 8'h00, '0, 1'b0, 8'h00, 4, 1'b0, OUT_IDLE);
    script[5]  = stim(CMD_WSTART, 8'h00, 8'hFF, '0, 1'b0, 8'h00, 1, 1'b1, OUT_BUSY);
    script[6]  = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'h00, 61, 1'b0, OUT_IDLE);
    script[7]  = stim(CMD_RSTART, 8'hFE, 8'h00, '0, 1'b1, 8'h00, 1, 1'b1, OUT_BUSY);
    script[8]  = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'h00, 29, 1'b0, OUT_IDLE);
    script[9]  = stim(CMD_WBYTE, 8'h00, 8'h00, '0, 1'b1, 8'h00, 1, 1'b1, OUT_BUSY);
    // nack on every bus
    script[10] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'hFF, 32, 1'b0, OUT_IDLE);
    script[11] = stim(CMD_WBYTE, 8'h00, 8'h00, '1, 1'b0, 8'h00, 1, 1'b1, OUT_BUSY);
    script[12] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'h00, 32, 1'b0, OUT_IDLE);
    script[13] = stim(CMD_RBYTE, 8'h00, 8'h00, '0, 1'b0, 8'h00, 1, 1'b1, OUT_BUSY);
    script[14] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'hA5, 39, 1'b0, OUT_IDLE);
    script[15] = stim(CMD_RBYTE, 8'h00, 8'h00, '0, 1'b1, 8'h00, 1, 1'b1, OUT_BUSY);
    script[16] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'h5A, 35, 1'b0, OUT_IDLE);
    script[17] = stim(CMD_WSTART, 8'hFF, 8'h00, '0, 1'b1, 8'h00, 1, 1'b0, OUT_IDLE);
    // nack on the address byte skips the register byte
    script[18] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'hFF, 33, 1'b0, OUT_IDLE);
    script[19] = stim(CMD_RSTART, 8'h00, 8'h00, '0, 1'b0, 8'h00, 1, 1'b0, OUT_IDLE);
    script[20] = stim(CMD_TICK, 8'h00, 8'h00, '0, 1'b0, 8'h01, 33, 1'b0, OUT_IDLE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      for (int r = 0; r < script[i].reps; r++) begin
        it.cmd = script[i].cmd;
        it.dev_addr = script[i].dev;
        it.reg_addr = script[i].regad;
        it.write_bytes = script[i].data;
        it.keep_going = script[i].keep;
        it.sda_sample = script[i].sample;
        send_item(it, script[i].chk, script[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cnt = 4'd1;
        1: cnt = 4'd8;
        2: cnt = 4'd0;
        3: cnt = 4'd15;
        4: cnt = 4'($urandom_range(2, 7));
        5: cnt = 4'($urandom_range(9, 14));
        default: cnt = 4'($urandom_range(0, 15));
      endcase
      drain();
      write_bus_count(cnt);
      tx_idle = (p != 0);
      rx_idle = (p != 0);
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (errors == 0) begin
      $display("multi_bus_i2c_master: match");
    end else begin
      $display("multi_bus_i2c_master: mismatch");
    end
    $finish;
  end

endmodule
